### src/imucf_pkg.sv
package imucf_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int CORDIC_MAX_STEPS = 24;
  localparam int STEP_W = 5;
  localparam int ANG_W  = 27;
  localparam int VEC_W  = 35;
  localparam int GT_W   = 33;
  localparam int ACC_W  = 51;

  localparam logic REG_BLEND_WEIGHT  = 1'b0;
  localparam logic REG_SAMPLE_PERIOD = 1'b1;

  localparam logic [15:0] BLEND_WEIGHT_RST  = 16'd58982;
  localparam logic [23:0] SAMPLE_PERIOD_RST = 24'd83886;

  localparam logic signed [ANG_W-1:0] DEG180 = ANG_W'(180 * 65536);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CORDIC,
    ST_GYRO,
    ST_MULW,
    ST_MULA,
    ST_SAT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic              load;
    logic              cordic_step;
    logic [STEP_W-1:0] step;
    logic              gyro_en;
    logic              mulw_en;
    logic              mula_en;
    logic              sat_en;
    logic              out_load;
    logic [1:0]        axis;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } status_t;

  function automatic logic signed [ANG_W-1:0] atan_deg(input logic [STEP_W-1:0] i);
    logic signed [ANG_W-1:0] t;
    unique case (i)
      5'd0:  t = 27'sd2949120;
      5'd1:  t = 27'sd1740967;
      5'd2:  t = 27'sd919879;
      5'd3:  t = 27'sd466945;
      5'd4:  t = 27'sd234379;
      5'd5:  t = 27'sd117304;
      5'd6:  t = 27'sd58666;
      5'd7:  t = 27'sd29335;
      5'd8:  t = 27'sd14668;
      5'd9:  t = 27'sd7334;
      5'd10: t = 27'sd3667;
      5'd11: t = 27'sd1833;
      5'd12: t = 27'sd917;
      5'd13: t = 27'sd458;
      5'd14: t = 27'sd229;
      5'd15: t = 27'sd115;
      5'd16: t = 27'sd57;
      5'd17: t = 27'sd29;
      5'd18: t = 27'sd14;
      5'd19: t = 27'sd7;
      5'd20: t = 27'sd4;
      5'd21: t = 27'sd2;
      5'd22: t = 27'sd1;
      default: t = 27'sd0;
    endcase
    return t;
  endfunction

endpackage

### src/imucf_if.sv
interface imu_sample_if;
  logic valid;
  logic ready;
  logic signed [15:0] accel_x;
  logic signed [15:0] accel_y;
  logic signed [15:0] accel_z;
  logic signed [15:0] gyro_x;
  logic signed [15:0] gyro_y;
  logic signed [15:0] gyro_z;
  modport source (output valid, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z,
                  input ready);
  modport sink (input valid, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z,
                output ready);
endinterface

interface imu_angle_if;
  logic valid;
  logic ready;
  logic signed [31:0] roll_angle;
  logic signed [31:0] pitch_angle;
  logic signed [31:0] yaw_angle;
  modport source (output valid, roll_angle, pitch_angle, yaw_angle, input ready);
  modport sink (input valid, roll_angle, pitch_angle, yaw_angle, output ready);
endinterface

### src/imucf_ctrl.sv
module imucf_ctrl
  import imucf_pkg::*;
#(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  status_t status,
  output cmd_t    cmd
);

  localparam int SW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;

  state_t state, state_next;
  logic [SW-1:0] step, step_next;
  logic [1:0] axis, axis_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= '0;
      axis  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
      axis  <= axis_next;
    end
  end

  always_comb begin
    state_next = state;
    step_next  = step;
    axis_next  = axis;
    unique case (state)
      ST_IDLE: begin
        step_next = '0;
        axis_next = '0;
        if (in_valid) state_next = ST_CORDIC;
      end
      ST_CORDIC: begin
        step_next = step + 1'b1;
        if (step == SW'(CORDIC_STEPS - 1)) state_next = ST_GYRO;
      end
      ST_GYRO, ST_MULW, ST_MULA: begin
        axis_next = axis + 2'd1;
        if (axis == 2'd2) begin
          axis_next = '0;
          unique case (state)
            ST_GYRO: state_next = ST_MULW;
            ST_MULW: state_next = ST_MULA;
            default: state_next = ST_SAT;
          endcase
        end
      end
      ST_SAT: state_next = ST_DONE;
      ST_DONE: begin
        if (status.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd             = '0;
    cmd.step        = STEP_W'(step);
    cmd.axis        = axis;
    in_ready        = (state == ST_IDLE);
    cmd.load        = (state == ST_IDLE) && in_valid;
    cmd.cordic_step = (state == ST_CORDIC);
    cmd.gyro_en     = (state == ST_GYRO);
    cmd.mulw_en     = (state == ST_MULW);
    cmd.mula_en     = (state == ST_MULA);
    cmd.sat_en      = (state == ST_SAT);
    cmd.out_load    = (state == ST_DONE) && status.out_free;
  end

endmodule

### src/imucf_datapath.sv
module imucf_datapath
  import imucf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [23:0] cfg_data,
  input  cmd_t        cmd,
  output status_t     status,
  imu_sample_if.sink  sample,
  imu_angle_if.source angle
);

  logic [15:0] weight;
  logic [23:0] period;
  logic signed [15:0] gyro [3];
  logic signed [VEC_W-1:0] cx [2];
  logic signed [VEC_W-1:0] cy [2];
  logic signed [ANG_W-1:0] cz [2];
  logic czero [2];
  logic signed [GT_W-1:0] gterm [3];
  logic signed [ACC_W-1:0] acc [3];
  logic signed [31:0] store [3];
  logic out_valid;

  logic signed [16:0] yn [2];
  logic signed [16:0] xn;
  logic signed [VEC_W-1:0] x0, y0 [2];
  logic signed [40:0] gprod;
  logic signed [49:0] wprod;
  logic signed [44:0] aprod;
  logic signed [ANG_W-1:0] asel;
  logic signed [17:0] aweight;
  logic signed [ACC_W-1:0] rnd [3];
  logic signed [34:0] shr [3];
  logic signed [ANG_W-1:0] tab;

  always_ff @(posedge clk) begin
    if (rst) begin
      weight <= BLEND_WEIGHT_RST;
      period <= SAMPLE_PERIOD_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BLEND_WEIGHT:  weight <= cfg_data[15:0];
        REG_SAMPLE_PERIOD: period <= cfg_data;
        default: ;
      endcase
    end
  end

  // CORDIC operands: roll = atan2(y, z), pitch = atan2(-x, z)
  always_comb begin
    xn    = 17'(sample.accel_z);
    yn[0] = 17'(sample.accel_y);
    yn[1] = -17'(sample.accel_x);
    x0    = VEC_W'(xn) <<< 16;
    y0[0] = VEC_W'(yn[0]) <<< 16;
    y0[1] = VEC_W'(yn[1]) <<< 16;
    tab   = atan_deg(cmd.step);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      gyro[0] <= sample.gyro_x;
      gyro[1] <= sample.gyro_y;
      gyro[2] <= sample.gyro_z;
      for (int u = 0; u < 2; u++) begin
        czero[u] <= (xn == 17'sd0) && (yn[u] == 17'sd0);
        if (xn < 0) begin
          cx[u] <= -x0;
          cy[u] <= -y0[u];
          cz[u] <= (yn[u] >= 0) ? DEG180 : -DEG180;
        end else begin
          cx[u] <= x0;
          cy[u] <= y0[u];
          cz[u] <= '0;
        end
      end
    end else if (cmd.cordic_step) begin
      for (int u = 0; u < 2; u++) begin
        if (cy[u] > 0) begin
          cx[u] <= cx[u] + (cy[u] >>> cmd.step);
          cy[u] <= cy[u] - (cx[u] >>> cmd.step);
          cz[u] <= cz[u] + tab;
        end else begin
          cx[u] <= cx[u] - (cy[u] >>> cmd.step);
          cy[u] <= cy[u] + (cx[u] >>> cmd.step);
          cz[u] <= cz[u] - tab;
        end
      end
    end
  end

  // Per-axis multiply phases, one axis a cycle
  always_comb begin
    gprod   = 41'(gyro[cmd.axis]) * $signed({1'b0, period});
    wprod   = $signed({1'b0, weight}) * 50'(gterm[cmd.axis]);
    aweight = $signed(18'(17'd65536 - {1'b0, weight}));
    unique case (cmd.axis)
      2'd0:    asel = czero[0] ? '0 : cz[0];
      2'd1:    asel = czero[1] ? '0 : cz[1];
      default: asel = '0;
    endcase
    aprod = 45'(aweight) * 45'(asel);
    for (int k = 0; k < 3; k++) begin
      rnd[k] = acc[k] + ACC_W'(32768);
      shr[k] = rnd[k][ACC_W-1:16];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 3; k++) store[k] <= '0;
    end else if (cmd.sat_en) begin
      for (int k = 0; k < 3; k++) begin
        if (shr[k] > 35'sh07FFF_FFFF)       store[k] <= 32'sh7FFF_FFFF;
        else if (shr[k] < -35'sh0_8000_0000) store[k] <= 32'sh8000_0000;
        else                                 store[k] <= shr[k][31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.gyro_en)
      gterm[cmd.axis] <= GT_W'(store[cmd.axis]) + GT_W'((gprod + 41'sd128) >>> 8);
    if (cmd.mulw_en)
      acc[cmd.axis] <= ACC_W'(wprod);
    else if (cmd.mula_en)
      acc[cmd.axis] <= acc[cmd.axis] + ACC_W'(aprod);
  end

  // Output register: hold the beat until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (angle.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      angle.roll_angle  <= store[0];
      angle.pitch_angle <= store[1];
      angle.yaw_angle   <= store[2];
    end
  end

  assign angle.valid     = out_valid;
  assign status.out_free = !out_valid || angle.ready;

endmodule

### src/imu_complementary_filter_top.sv
// IMU complementary filter: roll, pitch and decaying yaw from six-axis samples.
//
// Input channel "sample" carries one beat per IMU sample (three accel axes,
// three gyro counts). Output channel "angle" returns one beat per sample with
// the new roll, pitch and yaw, signed Q15.16 degrees, saturated.
// Configuration: write blend_weight (index 0) and sample_period (index 1)
// through cfg_we/cfg_index/cfg_data while the block is idle.
//
// Sequence: an accepted sample is loaded, then the two atan2 CORDIC lanes
// step once per cycle in parallel, then a shared multiply phase walks the
// three axes (gyro term, gyro weight, accel weight) and saturates before
// the result beat is loaded into the output register.
// One sample is processed at a time; a new sample is taken as soon as the
// previous result sits in the output register.
// Reset clears the three angles to zero and reloads the register defaults.
// When the receiver stalls, the result beat holds; a finished second result
// waits in the datapath until the output register frees up.
module imu_complementary_filter_top
  import imucf_pkg::*;
#(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [23:0] cfg_data,
  imu_sample_if.sink  sample,
  imu_angle_if.source angle
);

  cmd_t    cmd;
  status_t status;

  // Sequence the CORDIC and multiply phases
  imucf_ctrl #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (sample.valid),
    .in_ready (sample.ready),
    .status   (status),
    .cmd      (cmd)
  );

  // Hold angles, config and the output register
  imucf_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status),
    .sample    (sample),
    .angle     (angle)
  );

endmodule

### dv/imu_filter_scoreboard.sv
class imu_filter_scoreboard;
  logic [15:0] weight;
  logic [23:0] period;
  logic signed [31:0] roll_q, pitch_q, yaw_q;
  logic signed [31:0] exp_roll[$], exp_pitch[$], exp_yaw[$];
  int errors;

  function new();
    weight = imucf_pkg::BLEND_WEIGHT_RST;
    period = imucf_pkg::SAMPLE_PERIOD_RST;
    roll_q = 0;
    pitch_q = 0;
    yaw_q = 0;
    errors = 0;
  endfunction

  function longint floor_shift(longint v, int n);
    return v >>> n;
  endfunction

  function longint cordic_deg(longint yn, longint xn);
    longint x, y, z, dx, dy;
    if (xn == 0 && yn == 0) return 0;
    x = xn * 65536;
    y = yn * 65536;
    z = 0;
    if (x < 0) begin
      z = (y >= 0) ? 180 * 65536 : -180 * 65536;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < imucf_pkg::CORDIC_STEPS_DEF; i++) begin
      dx = floor_shift(y, i);
      dy = floor_shift(x, i);
      if (y > 0) begin
        x += dx; y -= dy; z += longint'(imucf_pkg::atan_deg(5'(i)));
      end else begin
        x -= dx; y += dy; z -= longint'(imucf_pkg::atan_deg(5'(i)));
      end
    end
    return z;
  endfunction

  function logic signed [31:0] fuse(longint g, longint a);
    longint w, s;
    w = longint'(weight);
    s = floor_shift(w * g + (65536 - w) * a + 32768, 16);
    if (s > 64'sd2147483647) return 32'h7fffffff;
    if (s < -64'sd2147483648) return 32'h80000000;
    return s[31:0];
  endfunction

  function longint rate_term(logic signed [31:0] q, logic signed [15:0] g);
    return longint'(q) + floor_shift(longint'(g) * longint'(period) + 128, 8);
  endfunction

  function void note_sample(logic signed [15:0] ax, ay, az, gx, gy, gz);
    longint rg, pg, yg;
    rg = rate_term(roll_q, gx);
    pg = rate_term(pitch_q, gy);
    yg = rate_term(yaw_q, gz);
    roll_q = fuse(rg, cordic_deg(longint'(ay), longint'(az)));
    pitch_q = fuse(pg, cordic_deg(-longint'(ax), longint'(az)));
    yaw_q = fuse(yg, 0);
    exp_roll.push_back(roll_q);
    exp_pitch.push_back(pitch_q);
    exp_yaw.push_back(yaw_q);
  endfunction

  function void check_angles(logic signed [31:0] r, p, y);
    logic signed [31:0] er, ep, ey;
    if (exp_roll.size() == 0) begin
      $error("unexpected angle beat roll=%0d pitch=%0d yaw=%0d", r, p, y);
      errors++;
      return;
    end
    er = exp_roll.pop_front();
    ep = exp_pitch.pop_front();
    ey = exp_yaw.pop_front();
    if (r !== er) begin $error("roll_angle exp %0d got %0d", er, r); errors++; end
    if (p !== ep) begin $error("pitch_angle exp %0d got %0d", ep, p); errors++; end
    if (y !== ey) begin $error("yaw_angle exp %0d got %0d", ey, y); errors++; end
  endfunction

  function int pending();
    return exp_roll.size();
  endfunction
endclass

### dv/tb_imu_complementary_filter_top.sv
module tb_imu_complementary_filter_top;
  import imucf_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic        cfg_index = REG_BLEND_WEIGHT;
  logic [23:0] cfg_data = '0;
  bit          rx_stall = 1'b0;

  imu_sample_if sample ();
  imu_angle_if  angle ();

  imu_filter_scoreboard sb = new();

  imu_complementary_filter_top i_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .sample(sample), .angle(angle)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Check every result beat against the oldest predicted angles.
  always @(posedge clk) begin
    if (!rst && angle.valid && angle.ready)
      sb.check_angles(angle.roll_angle, angle.pitch_angle, angle.yaw_angle);
  end

  // Receiver: stall in runs; some phases keep ready high throughout.
  always @(posedge clk) begin
    if (rst) begin
      angle.ready <= 1'b0;
    end else if (rx_stall) begin
      angle.ready <= ($urandom_range(0, 9) > 3) ? (($urandom_range(0, 40) != 0) ?
                     1'b1 : 1'b0) : ($urandom_range(0, 3) == 0);
    end else begin
      angle.ready <= 1'b1;
    end
  end

  // Drive one sample beat, hold valid until accepted, drop it afterwards unless keep is set.
  task automatic send_sample(logic signed [15:0] ax, ay, az, gx, gy, gz, bit keep);
    sample.valid   <= 1'b1;
    sample.accel_x <= ax;
    sample.accel_y <= ay;
    sample.accel_z <= az;
    sample.gyro_x  <= gx;
    sample.gyro_y  <= gy;
    sample.gyro_z  <= gz;
    do @(posedge clk); while (!sample.ready);
    sb.note_sample(ax, ay, az, gx, gy, gz);
    if (!keep) begin
      sample.valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // Random gap between bursts; zero means back to back.
  task automatic burst_gap();
    int n;
    n = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
    if (n > 0) begin
      sample.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic drain();
    while (sb.pending() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // Write one register; the block must be idle.
  task automatic write_reg(logic idx, logic [23:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_BLEND_WEIGHT) sb.weight = val[15:0];
    else sb.period = val;
    @(posedge clk);
  endtask

  function automatic logic signed [15:0] pick_axis();
    case ($urandom_range(0, 7))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'sd0;
      3: return 16'(signed'($urandom_range(0, 8)) - 4);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic random_phase(int count);
    int left;
    int blen;
    left = count;
    while (left > 0) begin
      blen = $urandom_range(1, 12);
      if (blen > left) blen = left;
      for (int k = 0; k < blen; k++)
        send_sample(pick_axis(), pick_axis(), pick_axis(),
                    pick_axis(), pick_axis(), pick_axis(), k != blen - 1);
      left -= blen;
      burst_gap();
    end
  endtask

  initial begin
    sample.valid = 1'b0;
    {sample.accel_x, sample.accel_y, sample.accel_z} = '0;
    {sample.gyro_x, sample.gyro_y, sample.gyro_z} = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: atan2 corners, both zero, zero x, negative x with zero y.
    send_sample(0, 0, 0, 0, 0, 0, 0);
    send_sample(0, 16'sd1000, 0, 16'sd100, -16'sd100, 16'sd50, 0);
    send_sample(0, -16'sd1000, 0, 0, 0, 0, 0);
    send_sample(16'sd500, 0, -16'sd800, 0, 0, 0, 0);
    send_sample(-16'sd500, 0, -16'sd800, 0, 0, 0, 0);
    send_sample(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 1);
    send_sample(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 1);
    send_sample(16'sh7fff, -16'sd1, 16'sh8000, 16'sd1, -16'sd1, 16'sh7fff, 0);
    send_sample(-16'sd1, 16'sd1, 16'sd1, 0, 0, 0, 0);
    // Hold off until all results are back.
    drain();

    // Saturate: full weight, longest period, big gyro pushes.
    write_reg(REG_BLEND_WEIGHT, 24'hffff);
    write_reg(REG_SAMPLE_PERIOD, 24'hffffff);
    for (int k = 0; k < 6; k++)
      send_sample(0, 0, 16'sd1, 16'sh7fff, 16'sh8000, 16'sh7fff, k != 5);
    for (int k = 0; k < 6; k++)
      send_sample(0, 0, 16'sd1, 16'sh8000, 16'sh7fff, 16'sh8000, k != 5);
    drain();

    // Zero weight: accel only.
    write_reg(REG_BLEND_WEIGHT, 24'h0);
    write_reg(REG_SAMPLE_PERIOD, 24'h0);
    send_sample(16'sd300, -16'sd300, 16'sd300, 16'sd9, 16'sd9, 16'sd9, 0);
    send_sample(0, 0, 16'sh8000, 16'sh7fff, 0, 0, 0);
    drain();

    rx_stall = 1'b1;
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin write_reg(REG_BLEND_WEIGHT, 24'(BLEND_WEIGHT_RST));
                 write_reg(REG_SAMPLE_PERIOD, SAMPLE_PERIOD_RST); end
        1: begin write_reg(REG_BLEND_WEIGHT, 24'hffff);
                 write_reg(REG_SAMPLE_PERIOD, 24'(($urandom) & 24'hffffff)); end
        2: begin write_reg(REG_BLEND_WEIGHT, 24'($urandom_range(0, 65535)));
                 write_reg(REG_SAMPLE_PERIOD, 24'hffffff); end
        3: begin write_reg(REG_BLEND_WEIGHT, 24'h0);
                 write_reg(REG_SAMPLE_PERIOD, 24'h0); end
        default: begin write_reg(REG_BLEND_WEIGHT, 24'h8000);
                 write_reg(REG_SAMPLE_PERIOD, 24'($urandom_range(0, 16777215))); end
      endcase
      rx_stall = (ph != 3);
      random_phase(80);
      drain();
    end
    rx_stall = 1'b0;

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Timeout guard.
  initial begin
    #20ms;
    $display("CHECKS FAILED");
    $finish;
  end
endmodule

### filelist.f
src/imucf_pkg.sv
src/imucf_if.sv
src/imucf_ctrl.sv
src/imucf_datapath.sv
src/imu_complementary_filter_top.sv
dv/imu_filter_scoreboard.sv
dv/tb_imu_complementary_filter_top.sv
